[hw/rtl/ccw_pkg.sv]
// Shared constants for the text-mode console writer.
`timescale 1ns / 1ps
`default_nettype none

package ccw_pkg;

	// Default geometry
	localparam int DEF_COLUMNS   = 80;
	localparam int DEF_ROWS      = 25;
	localparam int DEF_TAB_WIDTH = 4;

	// Field widths
	localparam int CMD_W        = 2;
	localparam int CH_W         = 8;
	localparam int CELL_X_W     = 7;
	localparam int CELL_Y_W     = 5;
	localparam int CURSOR_ROW_W = 5;
	localparam int CURSOR_COL_W = 7;
	localparam int ATTR_W       = 8;
	localparam int CELL_W       = CH_W + ATTR_W;
	localparam int COLOUR_W     = 4;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = COLOUR_W;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PLACE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FG = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BG = 1'd1;

	// Character codes
	localparam logic [CH_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CH_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CH_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CH_W-1:0] CH_SPACE     = 8'd32;

	// Reset colours and the cell they give
	localparam logic [COLOUR_W-1:0] RESET_FG = 4'hF;
	localparam logic [COLOUR_W-1:0] RESET_BG = 4'h0;
	localparam logic [CELL_W-1:0] RESET_CELL = {RESET_BG, RESET_FG, CH_SPACE};

endpackage

`default_nettype wire

[hw/rtl/ccw_if.sv]
// Request and response channel interfaces of the console writer.
`timescale 1ns / 1ps
`default_nettype none

interface ccw_req_if;
	import ccw_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [CH_W-1:0]     ch;
	logic [CELL_X_W-1:0] cell_x;
	logic [CELL_Y_W-1:0] cell_y;

	modport source (output valid, cmd, ch, cell_x, cell_y, input ready);
	modport sink   (input valid, cmd, ch, cell_x, cell_y, output ready);
endinterface

interface ccw_rsp_if;
	import ccw_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [CURSOR_ROW_W-1:0] cursor_row;
	logic [CURSOR_COL_W-1:0] cursor_col;
	logic [CH_W-1:0]         read_char;
	logic [ATTR_W-1:0]       read_attr;

	modport source (output valid, cursor_row, cursor_col, read_char, read_attr, input ready);
	modport sink   (input valid, cursor_row, cursor_col, read_char, read_attr, output ready);
endinterface

`default_nettype wire

[hw/rtl/ccw_ram.sv]
// Generic single-clock RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ccw_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/text_mode_console_writer.sv]
// Top level of the text-mode console writer: screen store, cursor and command sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Payload                                        | Per request
// --------+-----+------------------------------------------------+------------
// req     | in  | cmd, ch, cell_x, cell_y                        | one command
// rsp     | out | cursor_row, cursor_col, read_char, read_attr   | one result
// cfg     | in  | cfg_we, cfg_idx, cfg_wdata (fg / bg colour)    | one write
//
// Sequence: put and place go from accept through the done state to the result;
//   a read adds the read state for the registered RAM read. A newline on the
//   bottom row adds a sweep that blanks one row, a clear a sweep of the whole
//   store. The sweep writes one cell per cycle through the single RAM write
//   port.
// Scrolling never moves data: the rows form a ring and top_q names the
//   physical row shown at the top; a scroll advances it and blanks one row.
// Reset: after arst_n rises the store is filled with reset-colour spaces,
//   all ROWS*COLUMNS cells (2000 by default), before the first request is taken.
//   Colour writes are taken during that pass and do not affect it.
// Stalls: a finished result waits in the output register; the sequencer
//   holds in its done state until the result slot frees up.

module text_mode_console_writer #(
	parameter int COLUMNS   = ccw_pkg::DEF_COLUMNS,
	parameter int ROWS      = ccw_pkg::DEF_ROWS,
	parameter int TAB_WIDTH = ccw_pkg::DEF_TAB_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ccw_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [ccw_pkg::CFG_DATA_W-1:0] cfg_wdata,
	ccw_req_if.sink                              req,
	ccw_rsp_if.source                            rsp
);
	import ccw_pkg::*;

	localparam int NCELLS = ROWS * COLUMNS;
	localparam int AW     = $clog2(NCELLS);
	localparam int RW     = $clog2(ROWS);
	localparam int CW     = $clog2(COLUMNS);
	localparam int TW     = CW + 5;

	typedef enum logic [2:0] {
		ST_INIT,   // clearing pass after reset
		ST_IDLE,   // waiting for a request
		ST_READ,   // RAM read data arrives
		ST_SWEEP,  // blanking a row or the whole store
		ST_DONE    // result waiting for the output slot
	} state_t;

	state_t state_q;

	// Colour registers
	logic [COLOUR_W-1:0] fg_q, bg_q;

	// Cursor: logical row/col, plus the physical row it maps to
	logic [RW-1:0] cur_row_q, cur_prow_q, top_q;
	logic [CW-1:0] cur_col_q;

	// Sweep control
	logic [AW-1:0]     sweep_addr_q, sweep_end_q;
	logic [CELL_W-1:0] fill_q;

	// Read result and output register
	logic [CH_W-1:0]         res_char_q;
	logic [ATTR_W-1:0]       res_attr_q;
	logic                    rsp_valid_q;
	logic [CURSOR_ROW_W-1:0] rsp_row_q;
	logic [CURSOR_COL_W-1:0] rsp_col_q;
	logic [CH_W-1:0]         rsp_char_q;
	logic [ATTR_W-1:0]       rsp_attr_q;

	// Modular add over the row ring
	function automatic logic [RW-1:0] wrap_add(input logic [RW-1:0] a, input logic [RW-1:0] b);
		logic [RW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (RW+1)'(ROWS)) begin
			s = s - (RW+1)'(ROWS);
		end
		return s[RW-1:0];
	endfunction

	logic [ATTR_W-1:0] attr;
	logic [CELL_W-1:0] space_cell;
	assign attr       = {bg_q, fg_q};
	assign space_cell = {attr, CH_SPACE};

	logic req_fire, out_free;
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// Addresses
	logic [AW-1:0] cur_base, cur_addr, tgt_addr, scroll_base;
	logic [RW-1:0] tgt_prow;
	logic          tgt_ok;
	logic [CW:0]   col_inc;
	logic [TW-1:0] col_tab;
	logic [CW-1:0] col_dec;

	assign cur_base    = AW'(cur_prow_q) * AW'(COLUMNS);
	assign cur_addr    = cur_base + AW'(cur_col_q);
	assign scroll_base = AW'(top_q) * AW'(COLUMNS);
	assign tgt_ok      = (32'(req.cell_x) < 32'(COLUMNS)) && (32'(req.cell_y) < 32'(ROWS));
	assign tgt_prow    = wrap_add(RW'(req.cell_y), top_q);
	assign tgt_addr    = AW'(tgt_prow) * AW'(COLUMNS) + AW'(req.cell_x);
	assign col_inc     = {1'b0, cur_col_q} + (CW+1)'(1);
	assign col_tab     = TW'(cur_col_q) + TW'(TAB_WIDTH);
	assign col_dec     = cur_col_q - CW'(1);

	// Command decode at accept
	logic [RW-1:0]     nxt_row, nxt_prow, nxt_top;
	logic [CW-1:0]     nxt_col;
	logic              line_feed, do_scroll, do_clear, do_read;
	logic              acc_we;
	logic [AW-1:0]     acc_waddr;
	logic [CELL_W-1:0] acc_wdata;

	always_comb begin
		nxt_row   = cur_row_q;
		nxt_col   = cur_col_q;
		nxt_prow  = cur_prow_q;
		nxt_top   = top_q;
		line_feed = 1'b0;
		do_scroll = 1'b0;
		do_clear  = 1'b0;
		do_read   = 1'b0;
		acc_we    = 1'b0;
		acc_waddr = cur_addr;
		acc_wdata = space_cell;
		case (req.cmd)
			CMD_PUT: begin
				case (req.ch)
					CH_NEWLINE: begin
						line_feed = 1'b1;
					end
					CH_BACKSPACE: begin
						// no-op at column zero
						if (cur_col_q != '0) begin
							nxt_col   = col_dec;
							acc_we    = 1'b1;
							acc_waddr = cur_base + AW'(col_dec);
						end
					end
					CH_TAB: begin
						if (col_tab >= TW'(COLUMNS)) begin
							line_feed = 1'b1;
						end else begin
							nxt_col = CW'(col_tab);
						end
					end
					default: begin
						acc_we    = 1'b1;
						acc_wdata = {attr, req.ch};
						if (col_inc >= (CW+1)'(COLUMNS)) begin
							line_feed = 1'b1;
						end else begin
							nxt_col = CW'(col_inc);
						end
					end
				endcase
				if (line_feed) begin
					nxt_col = '0;
					if (cur_row_q != RW'(ROWS - 1)) begin
						nxt_row  = cur_row_q + RW'(1);
						nxt_prow = wrap_add(cur_prow_q, RW'(1));
					end else begin
						// old top row becomes the new, blank bottom row
						do_scroll = 1'b1;
						nxt_top   = wrap_add(top_q, RW'(1));
						nxt_prow  = top_q;
					end
				end
			end
			CMD_PLACE: begin
				if (tgt_ok) begin
					acc_we    = 1'b1;
					acc_waddr = tgt_addr;
					acc_wdata = {attr, req.ch};
				end
			end
			CMD_CLEAR: begin
				do_clear = 1'b1;
				nxt_row  = '0;
				nxt_col  = '0;
				nxt_prow = '0;
				nxt_top  = '0;
			end
			CMD_READ: begin
				do_read = tgt_ok;
			end
			default: begin
			end
		endcase
	end

	// Screen store port control
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [CELL_W-1:0] mem_rdata;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sweep_addr_q;
		mem_wdata = fill_q;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = RESET_CELL;
			end
			ST_SWEEP: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				mem_we    = req_fire && acc_we;
				mem_waddr = acc_waddr;
				mem_wdata = acc_wdata;
			end
			default: begin
			end
		endcase
	end

	ccw_ram #(
		.WIDTH  (CELL_W),
		.DEPTH  (NCELLS),
		.ADDR_W (AW)
	) u_screen (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (tgt_addr),
		.rdata (mem_rdata)
	);

	// Colour registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= RESET_FG;
			bg_q <= RESET_BG;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FG:  fg_q <= cfg_wdata;
				REG_BG:  bg_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Cursor widened, then cut to the result field widths
	logic [RW+CURSOR_ROW_W-1:0] row_ext;
	logic [CW+CURSOR_COL_W-1:0] col_ext;
	assign row_ext = {{CURSOR_ROW_W{1'b0}}, cur_row_q};
	assign col_ext = {{CURSOR_COL_W{1'b0}}, cur_col_q};

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			cur_prow_q   <= '0;
			top_q        <= '0;
			sweep_addr_q <= '0;
			sweep_end_q  <= AW'(NCELLS - 1);
			fill_q       <= RESET_CELL;
			res_char_q   <= '0;
			res_attr_q   <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_row_q    <= '0;
			rsp_col_q    <= '0;
			rsp_char_q   <= '0;
			rsp_attr_q   <= '0;
		end else begin
			// the done state reloads the slot itself
			if (rsp_valid_q && rsp.ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT, ST_SWEEP: begin
					if (sweep_addr_q == sweep_end_q) begin
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
					end else begin
						sweep_addr_q <= sweep_addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						cur_row_q  <= nxt_row;
						cur_col_q  <= nxt_col;
						cur_prow_q <= nxt_prow;
						top_q      <= nxt_top;
						res_char_q <= '0;
						res_attr_q <= '0;
						fill_q     <= space_cell;
						if (do_clear) begin
							sweep_addr_q <= '0;
							sweep_end_q  <= AW'(NCELLS - 1);
							state_q      <= ST_SWEEP;
						end else if (do_scroll) begin
							sweep_addr_q <= scroll_base;
							sweep_end_q  <= scroll_base + AW'(COLUMNS - 1);
							state_q      <= ST_SWEEP;
						end else if (do_read) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_READ: begin
					res_char_q <= mem_rdata[CH_W-1:0];
					res_attr_q <= mem_rdata[CELL_W-1:CH_W];
					state_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_row_q   <= row_ext[CURSOR_ROW_W-1:0];
						rsp_col_q   <= col_ext[CURSOR_COL_W-1:0];
						rsp_char_q  <= res_char_q;
						rsp_attr_q  <= res_attr_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cursor_row = rsp_row_q;
	assign rsp.cursor_col = rsp_col_q;
	assign rsp.read_char  = rsp_char_q;
	assign rsp.read_attr  = rsp_attr_q;

	// Checks
	logic [RW-1:0] chk_prow;
	assign chk_prow = wrap_add(cur_row_q, top_q);

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cur_row_q) < 32'(ROWS)) && (32'(cur_col_q) < 32'(COLUMNS)) && (32'(top_q) < 32'(ROWS)))
		else $error("cursor or top row out of range");

	a_prow_map: assert property (@(posedge clk) disable iff (!arst_n)
		cur_prow_q == chk_prow)
		else $error("physical cursor row out of step with ring offset");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT || state_q == ST_SWEEP) |-> sweep_addr_q <= sweep_end_q)
		else $error("sweep ran past its end");

	a_read_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> $past(req_fire))
		else $error("read state entered without a request");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result loaded outside done state");

endmodule

`default_nettype wire
